FILE: hdl/packet_prefix_rule_classifier_assert.svh
// Assertion macros for the packet prefix rule classifier.
// Taken in by files that check their own logic; no other dependencies.
`ifndef PACKET_PREFIX_RULE_CLASSIFIER_ASSERT_SVH
`define PACKET_PREFIX_RULE_CLASSIFIER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define PPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define PPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PPR_ASSERT_NOW(label, clk, rst, ante, cons)
`define PPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/ppr_pkg.sv
// Shared types, codes and helpers for the packet prefix rule classifier.
// No dependencies.
package ppr_pkg;

   localparam int unsigned PREFIX_ENTRIES_DEF = 64;
   localparam int unsigned RULE_ENTRIES_DEF   = 256;
   localparam int unsigned PFX_GROUP          = 8;
   localparam int unsigned RULE_GROUP         = 16;

   localparam logic [2:0] CMD_CLASSIFY   = 3'd0;
   localparam logic [2:0] CMD_WR_PREFIX  = 3'd1;
   localparam logic [2:0] CMD_WR_RULE    = 3'd2;
   localparam logic [2:0] CMD_CLR_PREFIX = 3'd3;
   localparam logic [2:0] CMD_CLR_RULE   = 3'd4;

   localparam logic [2:0] VERDICT_ABORTED = 3'd0;
   localparam logic [2:0] VERDICT_DROP    = 3'd1;
   localparam logic [2:0] VERDICT_PASS    = 3'd2;

   localparam logic [2:0] WHY_HIT    = 3'd0;
   localparam logic [2:0] WHY_MISS   = 3'd1;
   localparam logic [2:0] WHY_NOSUB  = 3'd2;
   localparam logic [2:0] WHY_NONIP  = 3'd3;
   localparam logic [2:0] WHY_BAD    = 3'd4;
   localparam logic [2:0] WHY_PROTO  = 3'd5;
   localparam logic [2:0] WHY_WRITE  = 3'd6;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [5:0]  FULL_LEN   = 6'd32;
   localparam logic [2:0]  DEFAULT_ACTION_RST = 3'd1;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        eth_ok;
      logic [15:0] ethertype;
      logic        ip_ok;
      logic [7:0]  ip_proto;
      logic [31:0] src_addr;
      logic        l4_ok;
      logic [15:0] dst_port;
      logic [7:0]  entry_index;
      logic [5:0]  entry_prefix_len;
      logic [15:0] entry_subnet;
      logic [2:0]  entry_action;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [2:0]  why;
      logic [15:0] matched_subnet;
   } rsp_type;

   // wr: the item in the table's lookup stage leaves it this cycle.
   // load_a / load_b: the two following stages take new contents.
   typedef struct packed {
      logic wr;
      logic load_a;
      logic load_b;
   } pipe_ctl_type;

   function automatic logic [5:0] clamp_len(input logic [5:0] len);
      clamp_len = (len > FULL_LEN) ? FULL_LEN : len;
   endfunction

   function automatic logic [31:0] len_mask(input logic [5:0] len);
      len_mask = (len == 6'd0) ? 32'd0 : (~32'd0 << (FULL_LEN - len));
   endfunction

endpackage

FILE: hdl/ppr_prefix_match.sv
// Prefix table and longest-prefix match over two register stages.
// Depends on ppr_pkg.
module ppr_prefix_match import ppr_pkg::*; #(
   parameter int unsigned PREFIX_ENTRIES = PREFIX_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  pipe_ctl_type ctl,
   input  req_type      item,
   output logic         found,
   output logic [15:0]  subnet
);
   localparam int unsigned GROUPS = (PREFIX_ENTRIES + PFX_GROUP - 1) / PFX_GROUP;

   logic        valid_ff [PREFIX_ENTRIES];
   logic [31:0] addr_ff  [PREFIX_ENTRIES];
   logic [5:0]  len_ff   [PREFIX_ENTRIES];
   logic [15:0] sub_ff   [PREFIX_ENTRIES];

   logic        hit      [PREFIX_ENTRIES];
   logic        gfound_in [GROUPS];
   logic [5:0]  glen_in   [GROUPS];
   logic [15:0] gsub_in   [GROUPS];
   logic        gfound_ff [GROUPS];
   logic [5:0]  glen_ff   [GROUPS];
   logic [15:0] gsub_ff   [GROUPS];
   logic        found_in, found_ff;
   logic [15:0] subnet_in, subnet_ff;
   logic [5:0]  best_len;

   // Writes take effect as the item leaves the lookup stage, so every
   // classify item sees the table exactly as of its own place in order.
   always_ff @(posedge clock) begin
      for (int i = 0; i < PREFIX_ENTRIES; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ctl.wr && (32'(item.entry_index) == i)) begin
            if (item.cmd == CMD_WR_PREFIX) begin
               valid_ff[i] <= 1'b1;
            end else if (item.cmd == CMD_CLR_PREFIX) begin
               valid_ff[i] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PREFIX_ENTRIES; i++) begin
         if (ctl.wr && (32'(item.entry_index) == i) && (item.cmd == CMD_WR_PREFIX)) begin
            addr_ff[i] <= item.src_addr;
            len_ff[i]  <= clamp_len(item.entry_prefix_len);
            sub_ff[i]  <= item.entry_subnet;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < PREFIX_ENTRIES; i++) begin
         hit[i] = valid_ff[i] && (((item.src_addr ^ addr_ff[i]) & len_mask(len_ff[i])) == 32'd0);
      end
   end

   // First level: best entry within each group, lowest index on a tie.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         gfound_in[g] = 1'b0;
         glen_in[g]   = 6'd0;
         gsub_in[g]   = 16'd0;
         for (int j = 0; j < PFX_GROUP; j++) begin
            if ((g * PFX_GROUP + j) < PREFIX_ENTRIES) begin
               if (hit[g * PFX_GROUP + j] &&
                   (!gfound_in[g] || (len_ff[g * PFX_GROUP + j] > glen_in[g]))) begin
                  gfound_in[g] = 1'b1;
                  glen_in[g]   = len_ff[g * PFX_GROUP + j];
                  gsub_in[g]   = sub_ff[g * PFX_GROUP + j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         for (int g = 0; g < GROUPS; g++) begin
            gfound_ff[g] <= gfound_in[g];
            glen_ff[g]   <= glen_in[g];
            gsub_ff[g]   <= gsub_in[g];
         end
      end
   end

   always_comb begin
      found_in  = 1'b0;
      best_len  = 6'd0;
      subnet_in = 16'd0;
      for (int g = 0; g < GROUPS; g++) begin
         if (gfound_ff[g] && (!found_in || (glen_ff[g] > best_len))) begin
            found_in  = 1'b1;
            best_len  = glen_ff[g];
            subnet_in = gsub_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_b) begin
         found_ff  <= found_in;
         subnet_ff <= subnet_in;
      end
   end

   assign found  = found_ff;
   assign subnet = subnet_ff;

endmodule

FILE: hdl/ppr_rule_match.sv
// Rule table and exact match of subnet, protocol and port.
// Depends on ppr_pkg.
module ppr_rule_match import ppr_pkg::*; #(
   parameter int unsigned RULE_ENTRIES = RULE_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  pipe_ctl_type ctl,
   input  req_type      item,
   input  logic [15:0]  subnet,
   output logic         hit,
   output logic [2:0]   action
);
   localparam int unsigned GROUPS = (RULE_ENTRIES + RULE_GROUP - 1) / RULE_GROUP;

   logic        valid_ff  [RULE_ENTRIES];
   logic [15:0] rsub_ff   [RULE_ENTRIES];
   logic [7:0]  rproto_ff [RULE_ENTRIES];
   logic [15:0] rport_ff  [RULE_ENTRIES];
   logic [2:0]  ract_ff   [RULE_ENTRIES];

   logic        match    [RULE_ENTRIES];
   logic        ghit_in  [GROUPS];
   logic [2:0]  gact_in  [GROUPS];
   logic        ghit_ff  [GROUPS];
   logic [2:0]  gact_ff  [GROUPS];
   logic [15:0] key_port;

   always_ff @(posedge clock) begin
      for (int i = 0; i < RULE_ENTRIES; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ctl.wr && (32'(item.entry_index) == i)) begin
            if (item.cmd == CMD_WR_RULE) begin
               valid_ff[i] <= 1'b1;
            end else if (item.cmd == CMD_CLR_RULE) begin
               valid_ff[i] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RULE_ENTRIES; i++) begin
         if (ctl.wr && (32'(item.entry_index) == i) && (item.cmd == CMD_WR_RULE)) begin
            rsub_ff[i]   <= item.entry_subnet;
            rproto_ff[i] <= item.ip_proto;
            rport_ff[i]  <= item.dst_port;
            ract_ff[i]   <= item.entry_action;
         end
      end
   end

   // ICMP carries no port, so it is keyed on port zero.
   assign key_port = (item.ip_proto == PROTO_ICMP) ? 16'd0 : item.dst_port;

   always_comb begin
      for (int i = 0; i < RULE_ENTRIES; i++) begin
         match[i] = valid_ff[i] && (rsub_ff[i] == subnet) &&
                    (rproto_ff[i] == item.ip_proto) && (rport_ff[i] == key_port);
      end
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         ghit_in[g] = 1'b0;
         gact_in[g] = 3'd0;
         for (int j = RULE_GROUP - 1; j >= 0; j--) begin
            if ((g * RULE_GROUP + j) < RULE_ENTRIES) begin
               if (match[g * RULE_GROUP + j]) begin
                  ghit_in[g] = 1'b1;
                  gact_in[g] = ract_ff[g * RULE_GROUP + j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         for (int g = 0; g < GROUPS; g++) begin
            ghit_ff[g] <= ghit_in[g];
            gact_ff[g] <= gact_in[g];
         end
      end
   end

   always_comb begin
      hit    = 1'b0;
      action = 3'd0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (ghit_ff[g]) begin
            hit    = 1'b1;
            action = gact_ff[g];
         end
      end
   end

endmodule

FILE: hdl/packet_prefix_rule_classifier.sv
// Top level of the packet prefix rule classifier: pipeline control and verdict.
// Depends on ppr_pkg, ppr_prefix_match, ppr_rule_match and the assertion header.
//
// One item enters per cycle while the result side does not stall, and its result is
// offered from the output register behind stage 4; a stalled result holds back every
// stage behind it, and no item is lost or repeated. Stage 1 compares
// the source address against every prefix entry and picks a best entry per
// group of eight; stage 2 picks the best group; stage 3 compares the key against
// every rule and finds the first hit per group of sixteen; stage 4 picks the
// first group and forms the verdict into the output register. Table writes land
// as the item passes the stage that reads that table, so items always see the
// tables in order.
`include "packet_prefix_rule_classifier_assert.svh"
module packet_prefix_rule_classifier import ppr_pkg::*; #(
   parameter int unsigned PREFIX_ENTRIES = PREFIX_ENTRIES_DEF,
   parameter int unsigned RULE_ENTRIES   = RULE_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [2:0] csr_wdata
);
   logic       v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   req_type    item1_ff, item2_ff, item3_ff, item4_ff;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       en1, en2, en3, en4, en_out;
   logic       found3, found4_ff;
   logic [15:0] sub3, sub4_ff;
   logic       rule_hit;
   logic [2:0] rule_act;
   logic [2:0] default_action_ff;
   logic       has_result;
   pipe_ctl_type pfx_ctl, rule_ctl;

   assign en_out = !rsp_valid_ff || rsp_ready;
   assign en4    = !v4_ff || en_out;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         default_action_ff <= DEFAULT_ACTION_RST;
      end else begin
         if (en1)    v1_ff <= req_valid;
         if (en2)    v2_ff <= v1_ff;
         if (en3)    v3_ff <= v2_ff;
         if (en4)    v4_ff <= v3_ff;
         if (en_out) rsp_valid_ff <= v4_ff && has_result;
         if (csr_we) default_action_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) item1_ff <= req_data;
      if (en2) item2_ff <= item1_ff;
      if (en3) item3_ff <= item2_ff;
      if (en4) begin
         item4_ff  <= item3_ff;
         found4_ff <= found3;
         sub4_ff   <= sub3;
      end
      if (en_out) rsp_data_ff <= rsp_data_in;
   end

   assign pfx_ctl  = '{wr: v1_ff && en2, load_a: en2, load_b: en3};
   assign rule_ctl = '{wr: v3_ff && en4, load_a: en4, load_b: 1'b0};

   ppr_prefix_match #(.PREFIX_ENTRIES(PREFIX_ENTRIES)) u_prefix (
      .clock  (clock),
      .reset  (reset),
      .ctl    (pfx_ctl),
      .item   (item1_ff),
      .found  (found3),
      .subnet (sub3)
   );

   ppr_rule_match #(.RULE_ENTRIES(RULE_ENTRIES)) u_rule (
      .clock  (clock),
      .reset  (reset),
      .ctl    (rule_ctl),
      .item   (item3_ff),
      .subnet (sub3),
      .hit    (rule_hit),
      .action (rule_act)
   );

   // Unknown commands travel through but produce no result item.
   assign has_result = (item4_ff.cmd <= CMD_CLR_RULE);

   always_comb begin
      rsp_data_in = '{verdict: VERDICT_ABORTED, why: WHY_WRITE, matched_subnet: 16'd0};
      if (item4_ff.cmd == CMD_CLASSIFY) begin
         priority if (!item4_ff.eth_ok) begin
            rsp_data_in = '{verdict: VERDICT_DROP, why: WHY_BAD, matched_subnet: 16'd0};
         end else if (item4_ff.ethertype != ETYPE_IPV4) begin
            rsp_data_in = '{verdict: VERDICT_PASS, why: WHY_NONIP, matched_subnet: 16'd0};
         end else if (!item4_ff.ip_ok) begin
            rsp_data_in = '{verdict: VERDICT_DROP, why: WHY_BAD, matched_subnet: 16'd0};
         end else if (!found4_ff) begin
            rsp_data_in = '{verdict: default_action_ff, why: WHY_NOSUB, matched_subnet: 16'd0};
         end else if ((item4_ff.ip_proto != PROTO_TCP) && (item4_ff.ip_proto != PROTO_UDP) &&
                      (item4_ff.ip_proto != PROTO_ICMP)) begin
            rsp_data_in = '{verdict: VERDICT_DROP, why: WHY_PROTO, matched_subnet: sub4_ff};
         end else if (!item4_ff.l4_ok) begin
            rsp_data_in = '{verdict: VERDICT_DROP, why: WHY_BAD, matched_subnet: sub4_ff};
         end else if (rule_hit) begin
            rsp_data_in = '{verdict: rule_act, why: WHY_HIT, matched_subnet: sub4_ff};
         end else begin
            rsp_data_in = '{verdict: default_action_ff, why: WHY_MISS, matched_subnet: sub4_ff};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_data))
   `PPR_ASSERT_NOW(a_write_rsp, clock, reset, rsp_valid && (rsp_data.why == WHY_WRITE),
                   (rsp_data.verdict == VERDICT_ABORTED) && (rsp_data.matched_subnet == 16'd0))
   `PPR_ASSERT_NOW(a_nosub_zero, clock, reset, rsp_valid && (rsp_data.why == WHY_NOSUB),
                   rsp_data.matched_subnet == 16'd0)

endmodule

FILE: bench/tb_packet_prefix_rule_classifier.sv
// Self-checking bench for the packet prefix rule classifier: random and directed
// header and table items, checked in order against a behavioural table model.
// Depends on ppr_pkg and the classifier RTL.
module tb_packet_prefix_rule_classifier;
   import ppr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPFX  = PREFIX_ENTRIES_DEF;
   localparam int NRULE = RULE_ENTRIES_DEF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [2:0] csr_wdata = '0;

   packet_prefix_rule_classifier dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow copy of the tables and the default verdict.
   logic [2:0]  dflt_action;
   logic        pfx_vld [NPFX];
   logic [31:0] pfx_addr [NPFX];
   logic [5:0]  pfx_len [NPFX];
   logic [15:0] pfx_sub [NPFX];
   logic        rule_vld [NRULE];
   logic [15:0] rule_sub [NRULE];
   logic [7:0]  rule_proto [NRULE];
   logic [15:0] rule_port [NRULE];
   logic [2:0]  rule_act [NRULE];

   req_type pending_items[$];
   rsp_type expected_verdicts[$];
   int      errors = 0;
   bit      idle_enable = 1'b1;
   bit      hold_rsp = 1'b0;
   int      send_gap = 0;
   int      recv_gap = 0;

   function automatic rsp_type classify_item(input req_type r);
      rsp_type o;
      logic found;
      logic [5:0] best, ln;
      logic [15:0] sub, kport;
      logic [31:0] m;
      o = '0;
      if (!r.eth_ok) begin
         o.verdict = VERDICT_DROP; o.why = WHY_BAD; return o;
      end
      if (r.ethertype != ETYPE_IPV4) begin
         o.verdict = VERDICT_PASS; o.why = WHY_NONIP; return o;
      end
      if (!r.ip_ok) begin
         o.verdict = VERDICT_DROP; o.why = WHY_BAD; return o;
      end
      found = 1'b0; best = '0; sub = '0;
      for (int i = 0; i < NPFX; i++) begin
         if (!pfx_vld[i]) continue;
         ln = (pfx_len[i] > FULL_LEN) ? FULL_LEN : pfx_len[i];
         m = (ln == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - ln));
         if (((r.src_addr ^ pfx_addr[i]) & m) != 0) continue;
         if (!found || ln > best) begin
            found = 1'b1; best = ln; sub = pfx_sub[i];
         end
      end
      if (!found) begin
         o.verdict = dflt_action; o.why = WHY_NOSUB; return o;
      end
      o.matched_subnet = sub;
      if (r.ip_proto == PROTO_TCP || r.ip_proto == PROTO_UDP) kport = r.dst_port;
      else if (r.ip_proto == PROTO_ICMP) kport = '0;
      else begin
         o.verdict = VERDICT_DROP; o.why = WHY_PROTO; return o;
      end
      if (!r.l4_ok) begin
         o.verdict = VERDICT_DROP; o.why = WHY_BAD; return o;
      end
      for (int i = 0; i < NRULE; i++) begin
         if (rule_vld[i] && rule_sub[i] == sub && rule_proto[i] == r.ip_proto &&
             rule_port[i] == kport) begin
            o.verdict = rule_act[i]; o.why = WHY_HIT; return o;
         end
      end
      o.verdict = dflt_action; o.why = WHY_MISS;
      return o;
   endfunction

   // Applies one accepted item to the shadow tables; returns 0 if it has no result.
   function automatic bit apply_item(input req_type r, output rsp_type o);
      o = '0;
      o.verdict = VERDICT_ABORTED; o.why = WHY_WRITE;
      case (r.cmd)
         CMD_CLASSIFY: o = classify_item(r);
         CMD_WR_PREFIX: if (r.entry_index < NPFX) begin
            pfx_vld[r.entry_index] = 1'b1;
            pfx_addr[r.entry_index] = r.src_addr;
            pfx_len[r.entry_index] = r.entry_prefix_len;
            pfx_sub[r.entry_index] = r.entry_subnet;
         end
         CMD_WR_RULE: begin
            rule_vld[r.entry_index] = 1'b1;
            rule_sub[r.entry_index] = r.entry_subnet;
            rule_proto[r.entry_index] = r.ip_proto;
            rule_port[r.entry_index] = r.dst_port;
            rule_act[r.entry_index] = r.entry_action;
         end
         CMD_CLR_PREFIX: if (r.entry_index < NPFX) pfx_vld[r.entry_index] = 1'b0;
         CMD_CLR_RULE: rule_vld[r.entry_index] = 1'b0;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Driver: presents pending items, with random gaps between them.
   always @(posedge clock) begin
      rsp_type o;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (apply_item(req_data, o)) expected_verdicts.push_back(o);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (idle_enable && $urandom_range(0, 9) == 0)
                  send_gap <= $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result against the oldest expectation and stalls at random.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("result with nothing expected: %h", rsp_data);
               errors++;
            end else begin
               e = expected_verdicts.pop_front();
               if (rsp_data.verdict !== e.verdict) begin
                  $error("verdict: expected %0d, got %0d", e.verdict, rsp_data.verdict);
                  errors++;
               end
               if (rsp_data.why !== e.why) begin
                  $error("why: expected %0d, got %0d", e.why, rsp_data.why);
                  errors++;
               end
               if (rsp_data.matched_subnet !== e.matched_subnet) begin
                  $error("matched_subnet: expected %h, got %h",
                         e.matched_subnet, rsp_data.matched_subnet);
                  errors++;
               end
            end
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_enable && $urandom_range(0, 9) == 0)
               recv_gap <= $urandom_range(1, 10);
         end
      end
   end

   function automatic req_type blank_item(input logic [2:0] c);
      req_type r;
      r = '0;
      r.cmd = c;
      return r;
   endfunction

   function automatic req_type random_item();
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom, $urandom});
      return r;
   endfunction

   // Source addresses come from a small pool so that prefixes and rules get hit.
   logic [31:0] addr_pool [8];
   logic [15:0] sub_pool [4];
   logic [15:0] port_pool [4];

   function automatic logic [7:0] pick_proto();
      case ($urandom_range(0, 4))
         0: return PROTO_TCP;
         1: return PROTO_UDP;
         2: return PROTO_ICMP;
         3: return PROTO_TCP;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_type shaped_item();
      req_type r;
      int k;
      r = random_item();
      k = $urandom_range(0, 99);
      if (k < 8) begin
         r.cmd = CMD_WR_PREFIX;
         r.src_addr = addr_pool[$urandom_range(0, 7)] ^ ($urandom & 32'h0000_0FFF);
         r.entry_prefix_len = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(33, 63))
                                                         : 6'($urandom_range(0, 32));
         r.entry_subnet = sub_pool[$urandom_range(0, 3)];
         r.entry_index = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63));
      end else if (k < 18) begin
         r.cmd = CMD_WR_RULE;
         r.entry_subnet = sub_pool[$urandom_range(0, 3)];
         r.ip_proto = pick_proto();
         r.dst_port = (r.ip_proto == PROTO_ICMP) ? 16'd0 : port_pool[$urandom_range(0, 3)];
      end else if (k < 21) begin
         r.cmd = CMD_CLR_PREFIX;
         r.entry_index = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63));
      end else if (k < 24) begin
         r.cmd = CMD_CLR_RULE;
      end else if (k < 27) begin
         r.cmd = 3'($urandom_range(5, 7));
      end else if (k < 35) begin
         r.cmd = CMD_CLASSIFY;
      end else begin
         r.cmd = CMD_CLASSIFY;
         r.eth_ok = ($urandom_range(0, 19) != 0);
         r.ip_ok = ($urandom_range(0, 19) != 0);
         r.l4_ok = ($urandom_range(0, 19) != 0);
         if ($urandom_range(0, 9) != 0) r.ethertype = ETYPE_IPV4;
         r.src_addr = addr_pool[$urandom_range(0, 7)] ^ (($urandom_range(0, 1) ? $urandom : 0)
                      & 32'h0000_FFFF);
         r.ip_proto = pick_proto();
         r.dst_port = port_pool[$urandom_range(0, 3)];
      end
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_verdicts.size() > 0)
         @(posedge clock);
      // Unknown commands give no result, so allow the pipeline to empty too.
      repeat (10) @(posedge clock);
   endtask

   task automatic set_default(input logic [2:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      dflt_action = v;
   endtask

   initial begin
      req_type r;
      dflt_action = DEFAULT_ACTION_RST;
      foreach (pfx_vld[i]) pfx_vld[i] = 1'b0;
      foreach (rule_vld[i]) rule_vld[i] = 1'b0;
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      foreach (sub_pool[i]) sub_pool[i] = 16'($urandom);
      foreach (port_pool[i]) port_pool[i] = 16'($urandom);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: every early exit, an empty table, then prefixes of every kind.
      r = blank_item(CMD_CLASSIFY); pending_items.push_back(r);
      r.eth_ok = 1'b1; r.ethertype = 16'hFFFF; pending_items.push_back(r);
      r.ethertype = ETYPE_IPV4; pending_items.push_back(r);
      r.ip_ok = 1'b1; r.src_addr = 32'hFFFF_FFFF; pending_items.push_back(r);
      r = blank_item(CMD_WR_PREFIX); r.entry_prefix_len = 6'd0; r.entry_subnet = 16'h0001;
      r.entry_index = 8'd63; pending_items.push_back(r);
      r.entry_index = 8'd5; r.entry_prefix_len = 6'd63; r.src_addr = addr_pool[0];
      r.entry_subnet = 16'hFFFF; pending_items.push_back(r);
      r.entry_index = 8'd255; pending_items.push_back(r);
      r = blank_item(CMD_WR_RULE); r.entry_subnet = 16'hFFFF; r.ip_proto = PROTO_ICMP;
      r.entry_action = 3'd7; r.entry_index = 8'd255; pending_items.push_back(r);
      r.ip_proto = PROTO_UDP; r.dst_port = 16'hFFFF; r.entry_action = 3'd4;
      r.entry_index = 8'd0; pending_items.push_back(r);
      r = blank_item(CMD_CLASSIFY); r.eth_ok = 1'b1; r.ethertype = ETYPE_IPV4;
      r.ip_ok = 1'b1;
      r.l4_ok = 1'b1; r.src_addr = addr_pool[0]; r.ip_proto = PROTO_ICMP;
      r.dst_port = 16'h1234;
      pending_items.push_back(r);
      r.ip_proto = PROTO_UDP; r.dst_port = 16'hFFFF; pending_items.push_back(r);
      r.ip_proto = PROTO_TCP; pending_items.push_back(r);
      r.ip_proto = 8'hFF; pending_items.push_back(r);
      r.ip_proto = PROTO_UDP; r.l4_ok = 1'b0; pending_items.push_back(r);
      r.l4_ok = 1'b1; r.src_addr = ~addr_pool[0]; pending_items.push_back(r);
      r = blank_item(CMD_CLR_PREFIX); r.entry_index = 8'd5; pending_items.push_back(r);
      r.entry_index = 8'd200; pending_items.push_back(r);
      r = blank_item(CMD_CLR_RULE); r.entry_index = 8'd255; pending_items.push_back(r);
      r = blank_item(3'd7); pending_items.push_back(r);
      r = blank_item(3'd5); pending_items.push_back(r);
      wait_drained();

      // Random phases, each under its own default verdict.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_default(3'd0);
            1: set_default(3'd7);
            2: set_default(3'($urandom));
            default: set_default(3'($urandom));
         endcase
         if (ph == 5) idle_enable = 1'b0;
         if (ph == 2) begin
            hold_rsp = 1'b1;
            for (int i = 0; i < 40; i++) pending_items.push_back(shaped_item());
            repeat (60) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 250; i++) pending_items.push_back(shaped_item());
         wait_drained();
      end

      if (errors == 0)
         $display("tb_packet_prefix_rule_classifier: done, clean");
      else
         $display("tb_packet_prefix_rule_classifier: done, errors");
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_packet_prefix_rule_classifier: done, errors");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/ppr_pkg.sv
hdl/ppr_prefix_match.sv
hdl/ppr_rule_match.sv
hdl/packet_prefix_rule_classifier.sv
bench/tb_packet_prefix_rule_classifier.sv
